@@ rtl/rsna_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsna_pkg
// Shared types and constants for the rds station name assembler.
// ----------------------------------------------------------------------------
package rsna_pkg;

    localparam int NAME_CHARS = 8;
    localparam int CHAR_W     = 8;
    localparam int BLOCK_W    = 16;
    localparam int SEG_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7E;

    localparam logic [CFG_IDX_W-1:0] REG_DBUF_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_MK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_0A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_0B = 2'd3;

    localparam logic [BLOCK_W-1:0] RST_TYPE_MK = 16'hF800;
    localparam logic [BLOCK_W-1:0] RST_CODE_0A = 16'h0000;
    localparam logic [BLOCK_W-1:0] RST_CODE_0B = 16'h0800;

    localparam logic OP_GROUP = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [BLOCK_W-1:0] block_b;
        logic [BLOCK_W-1:0] block_d;
    } t_in_item;

    typedef struct packed {
        logic [NAME_CHARS*CHAR_W-1:0] station_name;
        logic                         group_accepted;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic              clear;
        logic              write;
        logic              dbuf;
        logic [CHAR_W-1:0] chr;
    } t_lane_ctl;

    typedef logic [NAME_CHARS-1:0][CHAR_W-1:0] t_name_arr;

endpackage : rsna_pkg
`default_nettype wire

@@ rtl/rds_station_name_assembler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rds_station_name_assembler
// Assembles the eight-character RDS station name from 0A/0B groups.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | i_in_valid / o_in_stall   | i_in_data  (opcode, block_b, block_d)
//  out     | o_out_valid / i_out_stall | o_out_data (station_name, accepted)
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item per cycle unless o_in_stall is high, one result per item
// the eight lanes update in the cycle of acceptance, results sit in an
// output register backed by a one-item skid stage
// o_in_stall rises only when both output register and skid stage are full
// reset sets the name stores to spaces and the registers to defaults
// ----------------------------------------------------------------------------
module rds_station_name_assembler (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire rsna_pkg::t_in_item               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output rsna_pkg::t_out_item                   o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rsna_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rsna_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rsna_pkg::*;

    logic               r_dbuf;
    logic [BLOCK_W-1:0] r_type_mk, r_code_0a, r_code_0b;
    logic               full, acc, is_group, grp_ok;
    logic [BLOCK_W-1:0] masked;
    logic [SEG_W-1:0]   seg;
    t_lane_ctl          lane_ctl [NAME_CHARS];
    t_name_arr          next_chars;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbuf    <= 1'b1;
            r_type_mk <= RST_TYPE_MK;
            r_code_0a <= RST_CODE_0A;
            r_code_0b <= RST_CODE_0B;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DBUF_EN: r_dbuf    <= i_cfg_data[0];
                REG_TYPE_MK: r_type_mk <= i_cfg_data;
                REG_CODE_0A: r_code_0a <= i_cfg_data;
                REG_CODE_0B: r_code_0b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = full;
    assign acc        = i_in_valid && !full;
    assign is_group   = (i_in_data.opcode == OP_GROUP);
    assign masked     = i_in_data.block_b & r_type_mk;
    assign grp_ok     = is_group && ((masked == r_code_0a) || (masked == r_code_0b));
    assign seg        = i_in_data.block_b[SEG_W-1:0];

    genvar g;
    generate
        for (g = 0; g < NAME_CHARS; g++) begin : g_lane
            always_comb begin
                lane_ctl[g].en    = acc;
                lane_ctl[g].clear = (i_in_data.opcode == OP_CLEAR);
                lane_ctl[g].write = grp_ok && (seg == SEG_W'(g / 2));
                lane_ctl[g].dbuf  = r_dbuf;
                lane_ctl[g].chr   = ((g % 2) == 0) ? i_in_data.block_d[BLOCK_W-1 -: CHAR_W]
                                                   : i_in_data.block_d[CHAR_W-1:0];
            end

            rsna_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (lane_ctl[g]),
                .o_next_conf (next_chars[g])
            );
        end
    endgenerate

    rsna_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (acc),
        .i_chars     (next_chars),
        .i_accepted  (grp_ok),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule : rds_station_name_assembler
`default_nettype wire

@@ rtl/rsna_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsna_lane
// One name position: holds the confirmed and candidate character.
// ----------------------------------------------------------------------------
module rsna_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rsna_pkg::t_lane_ctl       i_ctl,
    output logic [rsna_pkg::CHAR_W-1:0]    o_next_conf
);
    import rsna_pkg::*;

    logic [CHAR_W-1:0] r_conf, r_cand;
    logic [CHAR_W-1:0] n_conf, n_cand;
    logic              printable;

    assign printable = (i_ctl.chr >= PRINT_LO) && (i_ctl.chr <= PRINT_HI);

    always_comb begin
        n_conf = r_conf;
        n_cand = r_cand;
        if (i_ctl.clear) begin
            n_conf = SPACE_CHAR;
            n_cand = SPACE_CHAR;
        end else if (i_ctl.write) begin
            if (r_cand == i_ctl.chr) begin
                n_conf = i_ctl.chr;
            end else if (printable) begin
                if (i_ctl.dbuf) begin
                    n_cand = i_ctl.chr;
                end else begin
                    n_conf = i_ctl.chr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf <= SPACE_CHAR;
            r_cand <= SPACE_CHAR;
        end else if (i_ctl.en) begin
            r_conf <= n_conf;
            r_cand <= n_cand;
        end
    end

    assign o_next_conf = n_conf;

endmodule : rsna_lane
`default_nettype wire

@@ rtl/rsna_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsna_merge
// Packs the lane characters into one result item; output register plus skid.
// ----------------------------------------------------------------------------
module rsna_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire rsna_pkg::t_name_arr  i_chars,
    input  wire logic                 i_accepted,
    output logic                      o_full,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rsna_pkg::t_out_item       o_out_data
);
    import rsna_pkg::*;

    t_out_item new_item;
    t_out_item r_out, r_skd;
    logic      r_out_vld, r_skd_vld;
    logic      out_free;

    always_comb begin
        new_item.group_accepted = i_accepted;
        for (int i = 0; i < NAME_CHARS; i++) begin
            new_item.station_name[(NAME_CHARS-1-i)*CHAR_W +: CHAR_W] = i_chars[i];
        end
    end

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_skd_vld || i_push;
            r_skd_vld <= 1'b0;
        end else if (i_push) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_vld ? r_skd : new_item;
        end else if (i_push) begin
            r_skd <= new_item;
        end
    end

    assign o_full      = r_skd_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule : rsna_merge
`default_nettype wire
